// ===== rtl/flux_mfm_pkg.sv =====
// ----------------------------------------------------------------------------
// flux_mfm_pkg
// Shared types and constants for the MFM flux decoder and sync hunter.
// ----------------------------------------------------------------------------
package flux_mfm_pkg;

  // Field widths
  localparam int unsigned IntervalW = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned PatW      = 32;
  localparam int unsigned IdxW      = 20;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;

  // Largest reported sample index
  localparam logic [IdxW-1:0] IdxMax = '1;

  // Register reset values
  localparam logic [ThrW-1:0] LongThrRst = 16'd720;
  localparam logic [ThrW-1:0] MidThrRst  = 16'd540;
  localparam logic [PatW-1:0] SyncPatRst = 32'h4489_4489;
  localparam logic [PatW-1:0] AltPatRst  = 32'h8944_8944;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_THR = 2'd0,
    CFG_MID_THR  = 2'd1,
    CFG_SYNC_PAT = 2'd2,
    CFG_ALT_PAT  = 2'd3
  } cfg_idx_e;

  // Configuration write, as seen by the front and back ends
  typedef struct packed {
    logic                en;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic restart;
    logic over_long;
    logic over_mid;
  } item_t;

endpackage

// ===== rtl/flux_mfm_front.sv =====
// ----------------------------------------------------------------------------
// flux_mfm_front
// Accepts flux intervals and classifies them against the two thresholds.
// ----------------------------------------------------------------------------
module flux_mfm_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  flux_mfm_pkg::cfg_wr_t                 cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [flux_mfm_pkg::IntervalW-1:0]    flux_interval_i,
  input  logic                                  restart_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output flux_mfm_pkg::item_t                   q_item_o
);

  logic [flux_mfm_pkg::ThrW-1:0] long_thr_q;
  logic [flux_mfm_pkg::ThrW-1:0] mid_thr_q;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_thr_q <= flux_mfm_pkg::LongThrRst;
      mid_thr_q  <= flux_mfm_pkg::MidThrRst;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        flux_mfm_pkg::CFG_LONG_THR: long_thr_q <= cfg_i.data[flux_mfm_pkg::ThrW-1:0];
        flux_mfm_pkg::CFG_MID_THR:  mid_thr_q  <= cfg_i.data[flux_mfm_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Accept while the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify: each threshold adds one leading zero cell
  always_comb begin
    q_item_o.restart   = restart_i;
    q_item_o.over_long = flux_interval_i > long_thr_q;
    q_item_o.over_mid  = flux_interval_i > mid_thr_q;
  end

endmodule

// ===== rtl/flux_mfm_queue.sv =====
// ----------------------------------------------------------------------------
// flux_mfm_queue
// Two-entry item queue between the front and back ends.
// ----------------------------------------------------------------------------
module flux_mfm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  flux_mfm_pkg::item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output flux_mfm_pkg::item_t item_o
);

  localparam int unsigned Depth = 2;

  flux_mfm_pkg::item_t mem_q [Depth];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == 2'(Depth);
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/flux_mfm_back.sv =====
// ----------------------------------------------------------------------------
// flux_mfm_back
// Shifts MFM cells into the window, hunts for sync and drives the results.
// ----------------------------------------------------------------------------
module flux_mfm_back #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  flux_mfm_pkg::cfg_wr_t               cfg_i,
  input  logic                                q_valid_i,
  input  flux_mfm_pkg::item_t                 q_item_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sync_found_o,
  output logic                                pattern_matched_o,
  output logic [flux_mfm_pkg::IdxW-1:0]       sample_index_o,
  output logic [flux_mfm_pkg::PatW-1:0]       cell_window_o,
  output logic                                locked_o
);

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [flux_mfm_pkg::PatW-1:0] sync_pat_q;
  logic [flux_mfm_pkg::PatW-1:0] alt_pat_q;

  logic [flux_mfm_pkg::PatW-1:0] win_q, win_d;
  logic [COUNT_BITS-1:0]         cnt_q, cnt_d;
  logic                          lock_q, lock_d;

  logic                          hit, alt_hit;
  logic [flux_mfm_pkg::IdxW-1:0] idx_before;
  logic [COUNT_BITS-1:0]         cnt_start;
  logic [3:0]                    step_en;
  logic [3:0]                    step_bit;

  logic                          out_valid_q;
  logic                          found_q, alt_q, lock_out_q;
  logic [flux_mfm_pkg::IdxW-1:0] idx_q;
  logic [flux_mfm_pkg::PatW-1:0] win_out_q;

  // Pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pat_q <= flux_mfm_pkg::SyncPatRst;
      alt_pat_q  <= flux_mfm_pkg::AltPatRst;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        flux_mfm_pkg::CFG_SYNC_PAT: sync_pat_q <= cfg_i.data[flux_mfm_pkg::PatW-1:0];
        flux_mfm_pkg::CFG_ALT_PAT:  alt_pat_q  <= cfg_i.data[flux_mfm_pkg::PatW-1:0];
        default: ;
      endcase
    end
  end

  // Take the next item whenever the output register is free or draining
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Cell steps: optional zero, optional zero, zero, one
  assign step_en  = {1'b1, 1'b1, q_item_i.over_mid, q_item_i.over_long};
  assign step_bit = 4'b1000;

  // Shift and compare after each cell, stop at the first match
  always_comb begin
    win_d     = q_item_i.restart ? '0 : win_q;
    cnt_start = q_item_i.restart ? '0 : cnt_q;
    lock_d    = q_item_i.restart ? 1'b0 : lock_q;
    cnt_d     = cnt_start;
    hit       = 1'b0;
    alt_hit   = 1'b0;

    if ((COUNT_BITS > flux_mfm_pkg::IdxW) &&
        (cnt_start > COUNT_BITS'(flux_mfm_pkg::IdxMax))) begin
      idx_before = flux_mfm_pkg::IdxMax;
    end else begin
      idx_before = flux_mfm_pkg::IdxW'(cnt_start);
    end

    if (!lock_d) begin
      for (int k = 0; k < 4; k++) begin
        if (step_en[k] && !hit) begin
          win_d = {win_d[flux_mfm_pkg::PatW-2:0], step_bit[k]};
          if (win_d == sync_pat_q) begin
            hit = 1'b1;
          end else if (win_d == alt_pat_q) begin
            hit     = 1'b1;
            alt_hit = 1'b1;
          end
        end
      end
      if (hit) begin
        lock_d = 1'b1;
      end else if (cnt_start != CntMax) begin
        cnt_d = cnt_start + COUNT_BITS'(1);
      end
    end
  end

  // Hunter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      lock_q <= 1'b0;
    end else if (q_pop_o) begin
      win_q  <= win_d;
      cnt_q  <= cnt_d;
      lock_q <= lock_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      found_q    <= hit;
      alt_q      <= alt_hit;
      idx_q      <= idx_before;
      win_out_q  <= win_d;
      lock_out_q <= lock_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sync_found_o      = found_q;
  assign pattern_matched_o = alt_q;
  assign sample_index_o    = idx_q;
  assign cell_window_o     = win_out_q;
  assign locked_o          = lock_out_q;

endmodule

// ===== rtl/flux_interval_mfm_sync_hunter_core.sv =====
// ----------------------------------------------------------------------------
// flux_interval_mfm_sync_hunter_core
// MFM flux-interval decoder with 32-bit sync hunter and lock.
// ----------------------------------------------------------------------------
// Path: an accepted item is first written into the queue, and its result is then
// captured in the output register.
// Throughput: one item per cycle while out_stall_i is low; the back end's four-cell
// shift-and-compare chain is combinational and handles a whole item.
// Reset: window, sample counter and lock clear; thresholds and sync patterns
// return to 720, 540, 0x44894489 and 0x89448944; queue and output empty.
module flux_interval_mfm_sync_hunter_core #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [flux_mfm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [flux_mfm_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [flux_mfm_pkg::IntervalW-1:0]  flux_interval_i,
  input  logic                                restart_i,
  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sync_found_o,
  output logic                                pattern_matched_o,
  output logic [flux_mfm_pkg::IdxW-1:0]       sample_index_o,
  output logic [flux_mfm_pkg::PatW-1:0]       cell_window_o,
  output logic                                locked_o
);

  flux_mfm_pkg::cfg_wr_t cfg;
  flux_mfm_pkg::item_t   push_item, head_item;
  logic                  q_full, q_push, q_valid, q_pop;

  // Bundle the configuration write
  always_comb begin
    cfg.en   = cfg_we_i;
    cfg.idx  = flux_mfm_pkg::cfg_idx_e'(cfg_idx_i);
    cfg.data = cfg_data_i;
  end

  flux_mfm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .flux_interval_i (flux_interval_i),
    .restart_i       (restart_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  flux_mfm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  flux_mfm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .q_valid_i         (q_valid),
    .q_item_i          (head_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sync_found_o      (sync_found_o),
    .pattern_matched_o (pattern_matched_o),
    .sample_index_o    (sample_index_o),
    .cell_window_o     (cell_window_o),
    .locked_o          (locked_o)
  );

endmodule
